// File: rtl/tc2x2_pkg.sv
// Package for the 2x2 stride-2 transposed convolution block.
// Holds phase encoding, command/status structs and fixed widths; no dependencies.
`timescale 1ns / 1ps
package tc2x2_pkg;
    localparam int unsigned MAX_DIM_DEF = 64;
    localparam int unsigned CH_MAX      = 1024;
    localparam int unsigned VAL_W       = 16;
    localparam int unsigned PIX_W       = 32;
    localparam int unsigned CFG_W       = 11;
    localparam int unsigned TAPS        = 4;

    // Configuration register indexes
    localparam logic [1:0] REG_IN_DIM  = 2'd0;
    localparam logic [1:0] REG_IN_CH   = 2'd1;
    localparam logic [1:0] REG_OUT_CH  = 2'd2;

    localparam logic FUNC_DATA = 1'b0;
    localparam logic FUNC_READ = 1'b1;

    typedef enum logic [2:0] {
        ST_BIAS,
        ST_TAPS,
        ST_PIX,
        ST_DRAIN,
        ST_RMW,
        ST_RD_WAIT,
        ST_OUT
    } t_state;

    // Controller to datapath commands
    typedef struct packed {
        logic       load_bias;
        logic       load_tap;
        logic       pix_start;   // latch pixel, issue first cell read
        logic       rmw_step;    // write cell, read next
        logic       rd_issue;    // issue drain read
        logic       out_load;    // capture read data into output register
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic       rmw_done;    // fourth cell being written
    } t_sts;

    function automatic logic [PIX_W-1:0] sat_add(input logic signed [PIX_W-1:0] a,
                                                 input logic signed [PIX_W-1:0] b);
        logic signed [PIX_W:0] s;
        s = {a[PIX_W-1], a} + {b[PIX_W-1], b};
        if (s[PIX_W] != s[PIX_W-1])
            sat_add = s[PIX_W] ? {1'b1, {(PIX_W-1){1'b0}}} : {1'b0, {(PIX_W-1){1'b1}}};
        else
            sat_add = s[PIX_W-1:0];
    endfunction
endpackage

// File: rtl/tc2x2_dp.sv
// Datapath: kernel taps, bias, accumulator memory with read-modify-write of a 2x2 cell.
// Depends on tc2x2_pkg.
`timescale 1ns / 1ps
module tc2x2_dp import tc2x2_pkg::*; #(
    parameter int unsigned MAX_DIM = MAX_DIM_DEF,
    parameter int unsigned AW = $clog2(4 * MAX_DIM * MAX_DIM),
    parameter int unsigned DW = $clog2(MAX_DIM + 1),
    parameter int unsigned RW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_cmd                    i_cmd,
    output t_sts                    o_sts,
    input  logic signed [VAL_W-1:0] i_value,
    input  logic [1:0]              i_tap_idx,
    input  logic                    i_first_ch,
    input  logic [DW-1:0]           i_dim,
    input  logic [RW-1:0]           i_row,
    input  logic [RW-1:0]           i_col,
    input  logic [AW-1:0]           i_drain_addr,
    output logic signed [PIX_W-1:0] o_pixel
);
    localparam int unsigned DEPTH = 4 * MAX_DIM * MAX_DIM;

    logic [PIX_W-1:0]        r_mem [DEPTH];
    logic [PIX_W-1:0]        r_rdata;
    logic signed [VAL_W-1:0] r_taps [TAPS];
    logic signed [PIX_W-1:0] r_bias;
    logic signed [VAL_W-1:0] r_pix;
    logic [AW-1:0]           r_base;
    logic [AW-1:0]           r_od;
    logic [1:0]              r_k;
    logic                    r_first;
    logic signed [PIX_W-1:0] r_prod;
    logic [PIX_W-1:0]        r_pixel;

    logic [AW-1:0]           w_base;
    logic [AW-1:0]           w_od;
    logic [AW-1:0]           w_waddr;
    logic [AW-1:0]           w_raddr;
    logic [1:0]              n_k;
    logic signed [PIX_W-1:0] w_acc;

    // Output side is twice the input side; cell base is (2r)*od + 2c
    assign w_od   = AW'({i_dim, 1'b0});
    assign w_base = AW'(AW'({i_row, 1'b0}) * w_od) + AW'({i_col, 1'b0});

    function automatic logic [AW-1:0] cell_addr(input logic [AW-1:0] b,
                                                input logic [AW-1:0] od,
                                                input logic [1:0] k);
        cell_addr = b + (k[1] ? od : '0) + AW'(k[0]);
    endfunction

    assign n_k     = r_k + 2'd1;
    assign w_waddr = cell_addr(r_base, r_od, r_k);
    assign w_acc   = r_first ? r_bias : $signed(r_rdata);

    always_comb begin
        if (i_cmd.rd_issue)       w_raddr = i_drain_addr;
        else if (i_cmd.pix_start) w_raddr = w_base;
        else                      w_raddr = cell_addr(r_base, r_od, n_k);
    end

    assign o_sts.rmw_done = (r_k == 2'd3);

    // Store bias, taps and pixel context
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_bias) r_bias <= PIX_W'(i_value) <<< 8;
        if (i_cmd.load_tap)  r_taps[i_tap_idx] <= i_value;
        if (i_cmd.pix_start) begin
            r_pix   <= i_value;
            r_base  <= w_base;
            r_od    <= w_od;
            r_first <= i_first_ch;
            r_prod  <= PIX_W'(i_value * r_taps[0]);
        end
        if (i_cmd.rmw_step) r_prod <= PIX_W'(r_pix * r_taps[n_k]);
        if (i_cmd.out_load) r_pixel <= r_rdata;
    end

    // Advance the cell index during the read-modify-write sweep
    always_ff @(posedge i_clk) begin
        if (!i_rst_n)             r_k <= '0;
        else if (i_cmd.pix_start) r_k <= '0;
        else if (i_cmd.rmw_step)  r_k <= n_k;
    end

    // Accumulator memory: one write port, one registered read port; hold read data between reads
    always_ff @(posedge i_clk) begin
        if (i_cmd.rmw_step) r_mem[w_waddr] <= sat_add(w_acc, r_prod);
        if (i_cmd.rd_issue || i_cmd.pix_start || i_cmd.rmw_step)
            r_rdata <= r_mem[w_raddr];
    end

    assign o_pixel = r_pixel;
endmodule

// File: rtl/tc2x2_ctrl.sv
// Controller: phase state machine, channel/row/column/drain counters, handshakes.
// Depends on tc2x2_pkg.
`timescale 1ns / 1ps
module tc2x2_ctrl import tc2x2_pkg::*; #(
    parameter int unsigned MAX_DIM = MAX_DIM_DEF,
    parameter int unsigned AW = $clog2(4 * MAX_DIM * MAX_DIM),
    parameter int unsigned DW = $clog2(MAX_DIM + 1),
    parameter int unsigned RW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  logic           i_func,
    output logic           o_valid,
    input  logic           i_stall,
    output logic           o_last_of_map,
    output logic           o_last_of_all,
    input  logic           i_cfg_we,
    input  logic [1:0]     i_cfg_idx,
    input  logic [CFG_W-1:0] i_cfg_data,
    output t_cmd           o_cmd,
    input  t_sts           i_sts,
    output logic [1:0]     o_tap_idx,
    output logic           o_first_ch,
    output logic [DW-1:0]  o_dim,
    output logic [RW-1:0]  o_row,
    output logic [RW-1:0]  o_col,
    output logic [AW-1:0]  o_drain_addr
);
    localparam int unsigned CW = $clog2(CH_MAX);

    t_state          r_state, n_state;
    logic [6:0]      r_in_dim;
    logic [CFG_W-1:0] r_in_ch, r_out_ch;
    logic [CW-1:0]   r_ch, r_filt;
    logic [RW-1:0]   r_row, r_col;
    logic [1:0]      r_tap;
    logic [AW:0]     r_drain;
    logic            r_ovalid, r_lm, r_la;

    logic [DW-1:0]   w_dim;
    logic [CFG_W-1:0] w_ich, w_och;
    logic            w_acc, w_out_free;
    logic            w_last_col, w_last_row, w_last_ch, w_last_px, w_lm, w_lf;
    logic [AW+1:0]   w_total;

    // Clamp registers to their legal ranges
    always_comb begin
        if (r_in_dim == '0)                 w_dim = DW'(1);
        else if (32'(r_in_dim) > MAX_DIM)   w_dim = DW'(MAX_DIM);
        else                                w_dim = DW'(r_in_dim);
        w_ich = (r_in_ch == '0) ? CFG_W'(1) : (r_in_ch > CFG_W'(CH_MAX) ? CFG_W'(CH_MAX) : r_in_ch);
        w_och = (r_out_ch == '0) ? CFG_W'(1) : (r_out_ch > CFG_W'(CH_MAX) ? CFG_W'(CH_MAX) : r_out_ch);
    end

    assign w_total    = (AW+2)'({w_dim, 1'b0}) * (AW+2)'({w_dim, 1'b0});
    assign w_last_col = (DW'(r_col) + DW'(1)) >= w_dim;
    assign w_last_row = (DW'(r_row) + DW'(1)) >= w_dim;
    assign w_last_ch  = (CFG_W'(r_ch) + CFG_W'(1)) >= w_ich;
    assign w_last_px  = w_last_col && w_last_row;
    assign w_lm       = ((AW+2)'(r_drain) + (AW+2)'(1)) >= w_total;
    assign w_lf       = (CFG_W'(r_filt) + CFG_W'(1)) >= w_och;

    assign w_out_free = !r_ovalid || !i_stall;
    assign o_stall    = !(r_state == ST_BIAS || r_state == ST_TAPS
                          || r_state == ST_PIX || (r_state == ST_DRAIN && w_out_free));
    assign w_acc      = i_valid && !o_stall;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_BIAS:    if (w_acc && i_func == FUNC_DATA) n_state = ST_TAPS;
            ST_TAPS:    if (w_acc && i_func == FUNC_DATA && r_tap == 2'd3) n_state = ST_PIX;
            ST_PIX:     if (w_acc && i_func == FUNC_DATA) n_state = ST_RMW;
            ST_RMW:     if (i_sts.rmw_done) begin
                            if (!w_last_px) n_state = ST_PIX;
                            else if (w_last_ch) n_state = ST_DRAIN;
                            else n_state = ST_TAPS;
                        end
            ST_DRAIN:   if (w_acc && i_func == FUNC_READ) n_state = ST_RD_WAIT;
            ST_RD_WAIT: n_state = ST_OUT;
            ST_OUT:     n_state = r_lm ? ST_BIAS : ST_DRAIN;
            default:    n_state = ST_BIAS;
        endcase
    end

    // Commands to the datapath
    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            ST_BIAS:  o_cmd.load_bias = w_acc && i_func == FUNC_DATA;
            ST_TAPS:  o_cmd.load_tap  = w_acc && i_func == FUNC_DATA;
            ST_PIX:   o_cmd.pix_start = w_acc && i_func == FUNC_DATA;
            ST_RMW:   o_cmd.rmw_step  = 1'b1;
            ST_DRAIN: o_cmd.rd_issue  = w_acc && i_func == FUNC_READ;
            ST_OUT:   o_cmd.out_load  = 1'b1;
            default:  o_cmd = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_BIAS;
            r_in_dim <= 7'd1;
            r_in_ch  <= CFG_W'(1);
            r_out_ch <= CFG_W'(1);
            r_ch     <= '0;
            r_filt   <= '0;
            r_row    <= '0;
            r_col    <= '0;
            r_tap    <= '0;
            r_drain  <= '0;
            r_ovalid <= 1'b0;
            r_lm     <= 1'b0;
            r_la     <= 1'b0;
        end else begin
            r_state <= n_state;
            // Configuration writes
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_IN_DIM: r_in_dim <= i_cfg_data[6:0];
                    REG_IN_CH:  r_in_ch  <= i_cfg_data;
                    REG_OUT_CH: r_out_ch <= i_cfg_data;
                    default: ;
                endcase
            end
            if (o_cmd.load_bias) begin
                r_ch  <= '0;
                r_tap <= '0;
            end
            if (o_cmd.load_tap) begin
                r_tap <= r_tap + 2'd1;
                if (r_tap == 2'd3) begin
                    r_row <= '0;
                    r_col <= '0;
                end
            end
            // Advance pixel position after the cell sweep
            if (r_state == ST_RMW && i_sts.rmw_done) begin
                if (w_last_col) begin
                    r_col <= '0;
                    if (w_last_row) begin
                        r_row <= '0;
                        if (w_last_ch) begin
                            r_ch    <= '0;
                            r_drain <= '0;
                        end else begin
                            r_ch  <= r_ch + CW'(1);
                            r_tap <= '0;
                        end
                    end else r_row <= r_row + RW'(1);
                end else r_col <= r_col + RW'(1);
            end
            if (o_cmd.rd_issue) begin
                r_lm <= w_lm;
                r_la <= w_lm && w_lf;
                if (w_lm) begin
                    r_drain <= '0;
                    r_filt  <= w_lf ? '0 : r_filt + CW'(1);
                end else r_drain <= r_drain + (AW+1)'(1);
            end
            // Output register
            if (o_cmd.out_load) r_ovalid <= 1'b1;
            else if (r_ovalid && !i_stall) r_ovalid <= 1'b0;
        end
    end

    assign o_valid       = r_ovalid;
    assign o_last_of_map = r_lm;
    assign o_last_of_all = r_la;
    assign o_tap_idx     = r_tap;
    assign o_first_ch    = (r_ch == '0);
    assign o_dim         = w_dim;
    assign o_row         = r_row;
    assign o_col         = r_col;
    assign o_drain_addr  = r_drain[AW-1:0];
endmodule

// File: rtl/transposed_conv_2x2_stride2_top.sv
// Channel   | Signals                                 | Direction
// input     | i_valid, o_stall, i_func, i_value       | in
// output    | o_valid, i_stall, o_pixel, o_last_*     | out
// config    | i_cfg_we, i_cfg_idx, i_cfg_data         | in
// Bias and tap words are stored on accept; an accepted pixel then goes through a
// four-cell read-modify-write on the accumulator memory, with one write and one read port.
// A read request goes through the read data register, a wait state and the output register.
// Synchronous active-low reset; the accumulator memory is not cleared.
// Output stall holds the result; a new read waits until the output register frees.
// Top level: transposed convolution block; depends on tc2x2_pkg, tc2x2_ctrl, tc2x2_dp.
`timescale 1ns / 1ps
module transposed_conv_2x2_stride2_top import tc2x2_pkg::*; #(
    parameter int unsigned MAX_DIM = MAX_DIM_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic                    i_func,
    input  logic signed [VAL_W-1:0] i_value,
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic signed [PIX_W-1:0] o_pixel,
    output logic                    o_last_of_map,
    output logic                    o_last_of_all,
    input  logic                    i_cfg_we,
    input  logic [1:0]              i_cfg_idx,
    input  logic [CFG_W-1:0]        i_cfg_data
);
    localparam int unsigned AW = $clog2(4 * MAX_DIM * MAX_DIM);
    localparam int unsigned DW = $clog2(MAX_DIM + 1);
    localparam int unsigned RW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

    t_cmd          w_cmd;
    t_sts          w_sts;
    logic [1:0]    w_tap;
    logic          w_first;
    logic [DW-1:0] w_dim;
    logic [RW-1:0] w_row, w_col;
    logic [AW-1:0] w_daddr;

    tc2x2_ctrl #(.MAX_DIM(MAX_DIM), .AW(AW), .DW(DW), .RW(RW)) u_ctrl (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_func, .o_valid, .i_stall,
        .o_last_of_map, .o_last_of_all, .i_cfg_we, .i_cfg_idx, .i_cfg_data,
        .o_cmd(w_cmd), .i_sts(w_sts), .o_tap_idx(w_tap), .o_first_ch(w_first),
        .o_dim(w_dim), .o_row(w_row), .o_col(w_col), .o_drain_addr(w_daddr)
    );

    tc2x2_dp #(.MAX_DIM(MAX_DIM), .AW(AW), .DW(DW), .RW(RW)) u_dp (
        .i_clk, .i_rst_n, .i_cmd(w_cmd), .o_sts(w_sts), .i_value,
        .i_tap_idx(w_tap), .i_first_ch(w_first), .i_dim(w_dim),
        .i_row(w_row), .i_col(w_col), .i_drain_addr(w_daddr), .o_pixel
    );
endmodule

// File: rtl/tc2x2_chk.sv
// Port-level checker for the transposed convolution block, bound to the top level.
// Depends on tc2x2_pkg.
`timescale 1ns / 1ps
module tc2x2_chk import tc2x2_pkg::*; (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             o_valid,
    input logic             i_stall,
    input logic [PIX_W-1:0] o_pixel,
    input logic             o_last_of_map,
    input logic             o_last_of_all
);
    // Hold a stalled transaction
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_pixel) && $stable(o_last_of_map))
        else $error("stalled output changed");
    // Last of all implies last of map
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_last_of_all |-> o_last_of_map)
        else $error("last_of_all without last_of_map");
    // Results never come back to back: o_valid drops after a result is taken
    a_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall |=> !o_valid)
        else $error("back-to-back results");
endmodule

bind transposed_conv_2x2_stride2_top tc2x2_chk u_chk (
    .i_clk, .i_rst_n, .o_valid, .i_stall, .o_pixel, .o_last_of_map, .o_last_of_all
);
